### rtl/scla_pkg.sv
`timescale 1ns / 1ps

package scla_pkg;

  // Field and address widths
  localparam int unsigned ADDR_W       = 48;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned TAG_W        = 12;
  localparam int unsigned ENTRY_W      = TAG_W + 1;  // valid bit on top of the tag
  localparam int unsigned POLL_W       = 20;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned WINDOW_SHIFT = 15;         // window stride 0x8000
  localparam int unsigned OP_SHIFT     = 27;

  // Offsets inside one channel window
  localparam logic [ADDR_W-1:0] OFS_CMD    = 48'h00;
  localparam logic [ADDR_W-1:0] OFS_STATUS = 48'h08;
  localparam logic [ADDR_W-1:0] OFS_WDATA  = 48'h10;
  localparam logic [ADDR_W-1:0] OFS_RDATA  = 48'h18;

  localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = 20'd100000;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_RETURN = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ACT_BUS_WRITE = 2'd0,
    ACT_BUS_READ  = 2'd1,
    ACT_FINISH    = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    OUT_OK        = 3'd0,
    OUT_NOT_READY = 3'd1,
    OUT_NO_CHAN   = 3'd2,
    OUT_BUS_ERR   = 3'd3,
    OUT_TIMEOUT   = 3'd4
  } outcome_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OBSERVER_BASE = 2'd0,
    CFG_CHANNEL_BASE  = 2'd1,
    CFG_POLL_LIMIT    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [7:0]        entry_index;
    logic [DATA_W-1:0] map_word;
    logic [3:0]        slave_id;
    logic [15:0]       reg_addr;
    logic [7:0]        write_value;
    logic [DATA_W-1:0] return_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] bus_address;
    logic [DATA_W-1:0] bus_data;
    logic [2:0]        outcome;
    logic [7:0]        read_byte;
    logic [7:0]        channel;
    logic              last;
  } out_item_t;

endpackage

### rtl/scla_stream_if.sv
`timescale 1ns / 1ps

interface scla_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/spmi_channel_lookup_access_core.sv
`timescale 1ns / 1ps

// Channel lookup and single-byte access engine for the master side of a power-bus
// arbiter. Load items write the channel map (one 13-bit valid+tag entry per channel)
// held in a table memory with one write port and one registered read port; read and
// write requests scan that memory for the lowest channel carrying the wanted device
// tag, then emit the bus writes and status reads of the access, and bus read returns
// drive the status polling until done, error or timeout. Items are handled one at a
// time and in_i is ready only while the engine is idle. A load reads the old entry,
// then writes the new one. A request scans the table one entry per cycle through the
// memory read port, then sends its results (up to 3) through the output register as
// the output takes them. A bus read return sends a single result through the output
// register. After reset the table is cleared in a pass over all entries during which
// no input transfer is taken; configuration writes are taken at any time.
module spmi_channel_lookup_access_core
  import scla_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  scla_stream_if.sink          in_i,
  scla_stream_if.source        out_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(TABLE_ENTRIES);

  // Sequencer
  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,  // post-reset table clear
    ST_IDLE   = 5'b00010,
    ST_LOAD   = 5'b00100,  // old entry read back, write new entry
    ST_SEARCH = 5'b01000,  // pipelined table scan
    ST_EMIT   = 5'b10000   // push results into the output register
  } state_e;

  // Access phase, kept across items
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_POLL = 3'b010,
    PH_DATA = 3'b100
  } phase_e;

  // What the emit state sends
  typedef enum logic [1:0] {
    KIND_FINISH = 2'd0,
    KIND_START  = 2'd1,  // data/command writes plus first status read
    KIND_STATUS = 2'd2,
    KIND_RDATA  = 2'd3
  } kind_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  kind_e  kind_q, kind_d;

  logic [IDX_W-1:0]   clr_ptr_q, clr_ptr_d;
  logic [IDX_W-1:0]   scan_q, scan_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]   ld_idx_q, ld_idx_d;
  logic [ENTRY_W-1:0] ld_entry_q, ld_entry_d;
  logic [CNT_W-1:0]   occ_q, occ_d;

  logic               req_read_q, req_read_d;
  logic [7:0]         req_addr_lo_q, req_addr_lo_d;
  logic [7:0]         req_wval_q, req_wval_d;
  logic [ENTRY_W-1:0] want_q, want_d;

  logic               pend_read_q, pend_read_d;
  logic [POLL_W-1:0]  poll_cnt_q, poll_cnt_d;
  logic [ADDR_W-1:0]  win_addr_q, win_addr_d;
  logic [7:0]         act_chan_q, act_chan_d;

  logic [1:0]         emit_idx_q, emit_idx_d;
  logic [2:0]         fin_outcome_q, fin_outcome_d;
  logic [7:0]         fin_byte_q, fin_byte_d;

  logic [ADDR_W-1:0]  obs_base_q, obs_base_d;
  logic [ADDR_W-1:0]  chan_base_q, chan_base_d;
  logic [POLL_W-1:0]  poll_limit_q, poll_limit_d;

  logic               out_valid_q, out_valid_d;
  out_item_t          out_item_q, out_item_d;

  // Channel map memory
  logic [ENTRY_W-1:0] tag_mem [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] rd_data_q;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;

  logic               in_acc;
  logic               out_free;
  in_item_t           item;
  logic [9:0]         idx_ext;
  logic [15:0]        found_ext;
  logic [ADDR_W-1:0]  found_ofs;
  logic [DATA_W-1:0]  cmd_word;
  logic [ADDR_W-1:0]  res_ofs;
  out_item_t          res;

  assign item      = in_i.payload;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc    = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

  assign idx_ext   = {2'b00, item.entry_index};
  assign found_ext = 16'(cmp_idx_q);
  // channel * 0x8000
  assign found_ofs = ADDR_W'(found_ext[7:0]) << WINDOW_SHIFT;
  assign cmd_word  = (DATA_W'(req_read_q) << OP_SHIFT) | (DATA_W'(req_addr_lo_q) << 4);

  // Result for the current emit step
  always_comb begin
    res         = '0;
    res_ofs     = OFS_STATUS;
    res.channel = act_chan_q;
    unique case (kind_q)
      KIND_FINISH: begin
        res.action    = ACT_FINISH;
        res.outcome   = fin_outcome_q;
        res.read_byte = fin_byte_q;
        res.last      = 1'b1;
        // lookup failures carry no channel
        if (fin_outcome_q == OUT_NOT_READY || fin_outcome_q == OUT_NO_CHAN) begin
          res.channel = '0;
        end
      end
      KIND_START: begin
        if (req_read_q) begin
          // command write, then status read
          if (emit_idx_q == 2'd0) begin
            res.action   = ACT_BUS_WRITE;
            res_ofs      = OFS_CMD;
            res.bus_data = cmd_word;
          end else begin
            res.action = ACT_BUS_READ;
            res.last   = 1'b1;
          end
        end else begin
          // write data, command, then status read
          if (emit_idx_q == 2'd0) begin
            res.action   = ACT_BUS_WRITE;
            res_ofs      = OFS_WDATA;
            res.bus_data = DATA_W'(req_wval_q);
          end else if (emit_idx_q == 2'd1) begin
            res.action   = ACT_BUS_WRITE;
            res_ofs      = OFS_CMD;
            res.bus_data = cmd_word;
          end else begin
            res.action = ACT_BUS_READ;
            res.last   = 1'b1;
          end
        end
      end
      KIND_STATUS: begin
        res.action = ACT_BUS_READ;
        res.last   = 1'b1;
      end
      KIND_RDATA: begin
        res.action = ACT_BUS_READ;
        res_ofs    = OFS_RDATA;
        res.last   = 1'b1;
      end
    endcase
    if (kind_q != KIND_FINISH) begin
      res.bus_address = win_addr_q + res_ofs;
    end
  end

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    kind_d        = kind_q;
    clr_ptr_d     = clr_ptr_q;
    scan_d        = scan_q;
    cmp_idx_d     = cmp_idx_q;
    cmp_vld_d     = cmp_vld_q;
    ld_idx_d      = ld_idx_q;
    ld_entry_d    = ld_entry_q;
    occ_d         = occ_q;
    req_read_d    = req_read_q;
    req_addr_lo_d = req_addr_lo_q;
    req_wval_d    = req_wval_q;
    want_d        = want_q;
    pend_read_d   = pend_read_q;
    poll_cnt_d    = poll_cnt_q;
    win_addr_d    = win_addr_q;
    act_chan_d    = act_chan_q;
    emit_idx_d    = emit_idx_q;
    fin_outcome_d = fin_outcome_q;
    fin_byte_d    = fin_byte_q;
    obs_base_d    = obs_base_q;
    chan_base_d   = chan_base_q;
    poll_limit_d  = poll_limit_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_item_d    = out_item_q;
    mem_we        = 1'b0;
    mem_waddr     = ld_idx_q;
    mem_wdata     = ld_entry_q;
    mem_raddr     = scan_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OBSERVER_BASE: obs_base_d   = cfg_data_i;
        CFG_CHANNEL_BASE:  chan_base_d  = cfg_data_i;
        CFG_POLL_LIMIT:    poll_limit_d = cfg_data_i[POLL_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr_q;
        mem_wdata = '0;
        if (clr_ptr_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end else begin
          clr_ptr_d = clr_ptr_q + IDX_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          emit_idx_d = '0;
          unique case (item.opcode)
            OP_LOAD: begin
              // channels past the table size are dropped
              if (idx_ext < 10'(TABLE_ENTRIES)) begin
                mem_raddr  = idx_ext[IDX_W-1:0];
                ld_idx_d   = idx_ext[IDX_W-1:0];
                ld_entry_d = (item.map_word != '0) ?
                             {1'b1, item.map_word[19:8]} : '0;
                state_d    = ST_LOAD;
              end
            end
            OP_READ, OP_WRITE: begin
              // a request during an access is dropped
              if (phase_q == PH_IDLE) begin
                req_read_d    = (item.opcode == OP_READ);
                req_addr_lo_d = item.reg_addr[7:0];
                req_wval_d    = item.write_value;
                want_d        = {1'b1, item.slave_id, item.reg_addr[15:8]};
                if (occ_q == '0) begin
                  kind_d        = KIND_FINISH;
                  fin_outcome_d = OUT_NOT_READY;
                  fin_byte_d    = '0;
                  state_d       = ST_EMIT;
                end else begin
                  scan_d    = '0;
                  cmp_vld_d = 1'b0;
                  state_d   = ST_SEARCH;
                end
              end
            end
            OP_RETURN: begin
              fin_byte_d = '0;
              if (phase_q == PH_POLL) begin
                state_d = ST_EMIT;
                if (item.return_data[0]) begin
                  if (item.return_data[3:1] != 3'b000) begin
                    kind_d        = KIND_FINISH;
                    fin_outcome_d = OUT_BUS_ERR;
                    phase_d       = PH_IDLE;
                  end else if (pend_read_q) begin
                    kind_d  = KIND_RDATA;
                    phase_d = PH_DATA;
                  end else begin
                    kind_d        = KIND_FINISH;
                    fin_outcome_d = OUT_OK;
                    phase_d       = PH_IDLE;
                  end
                end else if (poll_cnt_q >= poll_limit_q) begin
                  kind_d        = KIND_FINISH;
                  fin_outcome_d = OUT_TIMEOUT;
                  phase_d       = PH_IDLE;
                end else begin
                  kind_d     = KIND_STATUS;
                  poll_cnt_d = poll_cnt_q + POLL_W'(1);
                end
              end else if (phase_q == PH_DATA) begin
                kind_d        = KIND_FINISH;
                fin_outcome_d = OUT_OK;
                fin_byte_d    = item.return_data[7:0];
                phase_d       = PH_IDLE;
                state_d       = ST_EMIT;
              end
            end
          endcase
        end
      end

      ST_LOAD: begin
        // read-modify-write keeps the occupied count exact
        mem_we = 1'b1;
        if (!rd_data_q[TAG_W] && ld_entry_q[TAG_W]) begin
          occ_d = occ_q + CNT_W'(1);
        end else if (rd_data_q[TAG_W] && !ld_entry_q[TAG_W]) begin
          occ_d = occ_q - CNT_W'(1);
        end
        state_d = ST_IDLE;
      end

      ST_SEARCH: begin
        // read address scan_q, compare the entry read last cycle
        mem_raddr = scan_q;
        cmp_vld_d = 1'b1;
        cmp_idx_d = scan_q;
        if (scan_q != LAST_IDX) begin
          scan_d = scan_q + IDX_W'(1);
        end
        if (cmp_vld_q) begin
          if (rd_data_q == want_q) begin
            act_chan_d  = found_ext[7:0];
            pend_read_d = req_read_q;
            win_addr_d  = (req_read_q ? obs_base_q : chan_base_q) + found_ofs;
            phase_d     = PH_POLL;
            poll_cnt_d  = POLL_W'(1);
            kind_d      = KIND_START;
            state_d     = ST_EMIT;
          end else if (cmp_idx_q == LAST_IDX) begin
            kind_d        = KIND_FINISH;
            fin_outcome_d = OUT_NO_CHAN;
            fin_byte_d    = '0;
            state_d       = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_item_d  = res;
          if (res.last) begin
            state_d = ST_IDLE;
          end else begin
            emit_idx_d = emit_idx_q + 2'd1;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      phase_q       <= PH_IDLE;
      kind_q        <= KIND_FINISH;
      clr_ptr_q     <= '0;
      scan_q        <= '0;
      cmp_idx_q     <= '0;
      cmp_vld_q     <= 1'b0;
      ld_idx_q      <= '0;
      ld_entry_q    <= '0;
      occ_q         <= '0;
      req_read_q    <= 1'b0;
      req_addr_lo_q <= '0;
      req_wval_q    <= '0;
      want_q        <= '0;
      pend_read_q   <= 1'b0;
      poll_cnt_q    <= '0;
      win_addr_q    <= '0;
      act_chan_q    <= '0;
      emit_idx_q    <= '0;
      fin_outcome_q <= '0;
      fin_byte_q    <= '0;
      obs_base_q    <= '0;
      chan_base_q   <= '0;
      poll_limit_q  <= POLL_LIMIT_RESET;
      out_valid_q   <= 1'b0;
      out_item_q    <= '0;
    end else begin
      state_q       <= state_d;
      phase_q       <= phase_d;
      kind_q        <= kind_d;
      clr_ptr_q     <= clr_ptr_d;
      scan_q        <= scan_d;
      cmp_idx_q     <= cmp_idx_d;
      cmp_vld_q     <= cmp_vld_d;
      ld_idx_q      <= ld_idx_d;
      ld_entry_q    <= ld_entry_d;
      occ_q         <= occ_d;
      req_read_q    <= req_read_d;
      req_addr_lo_q <= req_addr_lo_d;
      req_wval_q    <= req_wval_d;
      want_q        <= want_d;
      pend_read_q   <= pend_read_d;
      poll_cnt_q    <= poll_cnt_d;
      win_addr_q    <= win_addr_d;
      act_chan_q    <= act_chan_d;
      emit_idx_q    <= emit_idx_d;
      fin_outcome_q <= fin_outcome_d;
      fin_byte_q    <= fin_byte_d;
      obs_base_q    <= obs_base_d;
      chan_base_q   <= chan_base_d;
      poll_limit_q  <= poll_limit_d;
      out_valid_q   <= out_valid_d;
      out_item_q    <= out_item_d;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= tag_mem[mem_raddr];
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= ENTRIES_CNT)
    else $error("occupied count above table size");

  a_search_idle_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH |-> phase_q == PH_IDLE)
    else $error("table scan while an access is open");

  a_finish_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && kind_q == KIND_FINISH) |-> phase_q == PH_IDLE)
    else $error("finish sent with access still open");

  a_start_polls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && kind_q == KIND_START) |->
      (phase_q == PH_POLL && poll_cnt_q == POLL_W'(1)))
    else $error("access start without poll setup");
`endif

endmodule
